[rtl/aes_pkg.sv]
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int BLOCK_W    = 128;
    localparam int HALF_W     = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int LATENCY    = NUM_ROUNDS + 1;

    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] GF_POLY    = 8'h1b;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [HALF_W-1:0] block_high;
        logic [HALF_W-1:0] block_low;
    } t_block_in;

    typedef struct packed {
        logic [HALF_W-1:0] cipher_high;
        logic [HALF_W-1:0] cipher_low;
    } t_block_out;

    // what one round cell hands to the next
    typedef struct packed {
        logic               valid;
        logic [7:0]         rcon;
        logic [BLOCK_W-1:0] round_key;
        logic [BLOCK_W-1:0] state;
    } t_link;

    localparam logic [7:0] SBOX_TAB [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // multiply by x in gf(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX_TAB[w[31:24]], SBOX_TAB[w[23:16]], SBOX_TAB[w[15:8]], SBOX_TAB[w[7:0]]};
    endfunction

    // byte n of the state sits at bits 127-8n downward
    function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        int                 c;
        int                 r;
        int                 src;
        t = '0;
        for (c = 0; c < 4; c++) begin
            for (r = 0; r < 4; r++) begin
                src = 4 * ((c + r) & 3) + r;
                t[BLOCK_W-1-8*(4*c+r) -: 8] = SBOX_TAB[s[BLOCK_W-1-8*src -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] mix_cols(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        logic [31:0]        col;
        logic [7:0]         a0;
        logic [7:0]         a1;
        logic [7:0]         a2;
        logic [7:0]         a3;
        logic [7:0]         all_x;
        int                 c;
        t = '0;
        for (c = 0; c < 4; c++) begin
            col   = s[BLOCK_W-1-32*c -: 32];
            a0    = col[31:24];
            a1    = col[23:16];
            a2    = col[15:8];
            a3    = col[7:0];
            all_x = a0 ^ a1 ^ a2 ^ a3;
            t[BLOCK_W-1-32*c -: 32] = {a0 ^ all_x ^ xtime(a0 ^ a1),
                                       a1 ^ all_x ^ xtime(a1 ^ a2),
                                       a2 ^ all_x ^ xtime(a2 ^ a3),
                                       a3 ^ all_x ^ xtime(a3 ^ a0)};
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] next_round_key(input logic [BLOCK_W-1:0] k,
                                                          input logic [7:0]         rcon);
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        w3 = k[31:0];
        w0 = k[127:96] ^ sub_word({w3[23:0], w3[31:24]}) ^ {rcon, 24'h000000};
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

[rtl/aes128_block_encrypt.sv]
// channel   | handshake               | payload
// ----------+-------------------------+--------------------------------------
// request   | start (busy never high) | i_block: block_high, block_low
// result    | o_result_valid strobe   | o_cipher: cipher_high, cipher_low
// config    | i_cfg_we, i_cfg_idx     | i_cfg_data: key_high (0), key_low (1)
//
// a request is taken on every cycle start is high; busy stays low
// each request passes through one input register for the
// initial key add, then ten round cells, one aes round per cell and cycle
// round keys are expanded on the fly, each cell carrying its key to the next
// synchronous active-low reset clears the key to zero and empties the chain
// the result strobe lasts one cycle; the receiver cannot stall the pipeline
module aes128_block_encrypt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  aes_pkg::t_block_in              i_block,
    output logic                            o_result_valid,
    output aes_pkg::t_block_out             o_cipher,
    input  logic                            i_cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [aes_pkg::HALF_W-1:0]      i_cfg_data
);
    import aes_pkg::*;

    // cipher key registers
    logic [HALF_W-1:0]  r_key_high;
    logic [HALF_W-1:0]  r_key_low;
    logic [BLOCK_W-1:0] w_key;

    // chain head: plaintext after the round 0 key add
    t_link              r_head;
    logic               w_accept;

    // links between cells, entry 0 is the head register
    t_link              w_link [0:NUM_ROUNDS];

    assign w_key    = {r_key_high, r_key_low};
    assign busy     = 1'b0;           // fully pipelined, a request fits every cycle
    assign w_accept = start && !busy;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // head of the chain, only the valid bit is reset
    always_ff @(posedge i_clk) begin
        r_head.rcon      <= RCON_FIRST;
        r_head.round_key <= w_key;
        r_head.state     <= {i_block.block_high, i_block.block_low} ^ w_key;
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else begin
            r_head.valid <= w_accept;
        end
    end

    assign w_link[0] = r_head;

    // rounds 1 to 9 mix columns, round 10 does not
    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        aes_round_cell #(
            .IS_FINAL (g == NUM_ROUNDS - 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    // last cell register drives the result ports directly
    assign o_result_valid       = w_link[NUM_ROUNDS].valid;
    assign o_cipher.cipher_high = w_link[NUM_ROUNDS].state[BLOCK_W-1 -: HALF_W];
    assign o_cipher.cipher_low  = w_link[NUM_ROUNDS].state[HALF_W-1:0];

    // every result traces back to a request a fixed latency earlier
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy && i_rst_n, LATENCY))
        else $error("result without matching request");

    // every request taken out of reset comes out a fixed latency later
    a_request_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_accept && i_rst_n, LATENCY) |-> o_result_valid)
        else $error("request taken but no result after the pipeline latency");

    a_head_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head.valid == $past(w_accept && i_rst_n))
        else $error("head register out of step with accepted requests");

endmodule

[rtl/aes_round_cell.sv]
module aes_round_cell #(
    parameter bit IS_FINAL = 1'b0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  aes_pkg::t_link i_link,
    output aes_pkg::t_link o_link
);
    import aes_pkg::*;

    t_link              r_link;
    logic [BLOCK_W-1:0] n_key;
    logic [BLOCK_W-1:0] n_sub;
    logic [BLOCK_W-1:0] n_state;

    always_comb begin
        n_key   = next_round_key(i_link.round_key, i_link.rcon);
        n_sub   = sub_shift(i_link.state);
        n_state = (IS_FINAL ? n_sub : mix_cols(n_sub)) ^ n_key;
    end

    // only the valid bit is reset, the data fields just follow upstream
    always_ff @(posedge i_clk) begin
        r_link.rcon      <= xtime(i_link.rcon);
        r_link.round_key <= n_key;
        r_link.state     <= n_state;
        if (!i_rst_n) begin
            r_link.valid <= 1'b0;
        end else begin
            r_link.valid <= i_link.valid;
        end
    end

    assign o_link = r_link;

    a_valid_from_upstream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link.valid |-> $past(i_link.valid))
        else $error("round cell valid without upstream valid");

    a_rcon_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link.valid |-> r_link.rcon != 8'h00)
        else $error("round constant lost in chain");

endmodule
